// ----- src/assert_macros.svh -----
// Concurrent assertion helpers, clocked on aclk, off while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define CFA_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`define CFA_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/cfa_pkg.sv -----
`default_nettype none

package cfa_pkg;

    localparam int unsigned DEF_TABLE_DEPTH = 1024;
    localparam int unsigned DEF_FRAME_BYTES = 4096;

    localparam int unsigned ADDR_W    = 32;
    localparam int unsigned FIU_W     = 11;
    localparam int unsigned ACT_W     = 2;
    localparam int unsigned STAT_W    = 2;
    localparam int unsigned MARK_W    = 3;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [FIU_W-1:0] FIU_RESET = 11'd1024;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIU  = 1'd1;

    localparam logic [ACT_W-1:0] ACT_ALLOC = 2'd0;
    localparam logic [ACT_W-1:0] ACT_FREE  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOSPACE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_BAD     = 2'd2;

    localparam int unsigned MARK_TAKEN_BIT = 0;
    localparam int unsigned MARK_FIRST_BIT = 1;
    localparam int unsigned MARK_NEXT_BIT  = 2;

    typedef struct packed {
        logic              accept;
        logic              ptr_clr;
        logic              sweep_wr;
        logic              scan_step;
        logic              mark_wr;
        logic              free_load;
        logic              free_rd;
        logic              free_wr;
        logic              resp_load;
        logic              resp_use_addr;
        logic [STAT_W-1:0] resp_stat;
    } cfa_cmd_t;

    typedef struct packed {
        logic [ACT_W-1:0] act;
        logic             need_zero;
        logic             need_over;
        logic             free_bad;
        logic             sweep_last;
        logic             found;
        logic             scan_end;
        logic             mark_last;
        logic             free_more;
        logic             out_free;
    } cfa_stat_t;

endpackage

`default_nettype wire

// ----- src/cfa_ctrl.sv -----
`default_nettype none

module cfa_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire cfa_pkg::cfa_stat_t st,
    output cfa_pkg::cfa_cmd_t       cmd
);
    import cfa_pkg::*;

    localparam logic [3:0] S_INIT    = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_DECODE  = 4'd2;
    localparam logic [3:0] S_SCAN    = 4'd3;
    localparam logic [3:0] S_MARK    = 4'd4;
    localparam logic [3:0] S_FREE_RD = 4'd5;
    localparam logic [3:0] S_FREE_WR = 4'd6;
    localparam logic [3:0] S_CLEAR   = 4'd7;
    localparam logic [3:0] S_RESP    = 4'd8;

    logic [3:0]        state_reg, state_next;
    logic [STAT_W-1:0] stat_reg, stat_next;
    logic              use_addr_reg, use_addr_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_INIT;
            stat_reg     <= STAT_OK;
            use_addr_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            stat_reg     <= stat_next;
            use_addr_reg <= use_addr_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next    = state_reg;
        stat_next     = stat_reg;
        use_addr_next = use_addr_reg;
        cmd           = '0;
        cmd.accept    = s_tvalid && s_tready;
        cmd.resp_stat     = stat_reg;
        cmd.resp_use_addr = use_addr_reg;
        unique case (state_reg)
            S_INIT: begin
                cmd.sweep_wr = 1'b1;
                if (st.sweep_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (cmd.accept) begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                use_addr_next = 1'b0;
                state_next    = S_RESP;
                unique case (st.act)
                    ACT_ALLOC: begin
                        if (st.need_zero) begin
                            stat_next = STAT_BAD;
                        end else if (st.need_over) begin
                            stat_next = STAT_NOSPACE;
                        end else begin
                            cmd.ptr_clr = 1'b1;
                            state_next  = S_SCAN;
                        end
                    end
                    ACT_FREE: begin
                        if (st.free_bad) begin
                            stat_next = STAT_BAD;
                        end else begin
                            cmd.free_load = 1'b1;
                            state_next    = S_FREE_RD;
                        end
                    end
                    ACT_CLEAR: begin
                        cmd.ptr_clr = 1'b1;
                        state_next  = S_CLEAR;
                    end
                    default: begin
                        stat_next = STAT_BAD;
                    end
                endcase
            end
            S_SCAN: begin
                cmd.scan_step = 1'b1;
                if (st.found) begin
                    state_next = S_MARK;
                end else if (st.scan_end) begin
                    stat_next  = STAT_NOSPACE;
                    state_next = S_RESP;
                end
            end
            S_MARK: begin
                cmd.mark_wr = 1'b1;
                if (st.mark_last) begin
                    stat_next     = STAT_OK;
                    use_addr_next = 1'b1;
                    state_next    = S_RESP;
                end
            end
            S_FREE_RD: begin
                cmd.free_rd = 1'b1;
                state_next  = S_FREE_WR;
            end
            S_FREE_WR: begin
                cmd.free_wr = 1'b1;
                if (st.free_more) begin
                    state_next = S_FREE_RD;
                end else begin
                    stat_next  = STAT_OK;
                    state_next = S_RESP;
                end
            end
            S_CLEAR: begin
                cmd.sweep_wr = 1'b1;
                if (st.sweep_last) begin
                    stat_next  = STAT_OK;
                    state_next = S_RESP;
                end
            end
            S_RESP: begin
                if (st.out_free) begin
                    cmd.resp_load = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_INIT;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- src/cfa_dp.sv -----
`default_nettype none

module cfa_dp #(
    parameter int unsigned TABLE_DEPTH = cfa_pkg::DEF_TABLE_DEPTH,
    parameter int unsigned FRAME_BYTES = cfa_pkg::DEF_FRAME_BYTES
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [cfa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [cfa_pkg::ADDR_W-1:0]     cfg_wdata,
    input  wire logic [cfa_pkg::ACT_W-1:0]      in_action,
    input  wire logic [cfa_pkg::ADDR_W-1:0]     in_size_bytes,
    input  wire logic [cfa_pkg::ADDR_W-1:0]     in_free_address,
    input  wire cfa_pkg::cfa_cmd_t              cmd,
    output cfa_pkg::cfa_stat_t                  st,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [cfa_pkg::ADDR_W-1:0]          m_tdata,
    output logic [cfa_pkg::STAT_W-1:0]          m_tuser
);
    import cfa_pkg::*;

    // FRAME_BYTES is a power of two
    localparam int unsigned FS = $clog2(FRAME_BYTES);
    localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned NW = ADDR_W + 1 - FS;
    localparam int unsigned XW = ADDR_W + 1;

    logic [MARK_W-1:0] mark_mem [TABLE_DEPTH];
    logic [MARK_W-1:0] rdata_reg;

    logic [ADDR_W-1:0] base_reg;
    logic [FIU_W-1:0]  fiu_reg;
    logic [ACT_W-1:0]  act_reg;
    logic [NW-1:0]     need_reg;
    logic [ADDR_W-FS-1:0] idx_reg;
    logic              below_reg;

    logic [CW-1:0]     ptr_reg;
    logic [CW-1:0]     run_reg;
    logic [IW-1:0]     start_reg;
    logic [IW-1:0]     last_reg;
    logic [IW-1:0]     ridx_reg;
    logic              rv_reg;

    logic              out_valid_reg;
    logic [ADDR_W-1:0] out_addr_reg;
    logic [STAT_W-1:0] out_stat_reg;

    logic [CW-1:0]     n_cnt;
    logic [ADDR_W-1:0] base_aligned;
    logic [XW-1:0]     size_sum;
    logic [XW-1:0]     free_off;
    logic              ptr_lt_n;
    logic [CW-1:0]     run_plus;
    logic              rd_taken;
    logic              found;
    logic [IW-1:0]     start_found;
    logic [IW-1:0]     need_m1;
    logic [IW-1:0]     ptr_idx;
    logic [MARK_W-1:0] mark_word;
    logic              rd_en;
    logic              wr_en;
    logic [MARK_W-1:0] wr_data;

    assign n_cnt = (ADDR_W'(fiu_reg) > ADDR_W'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
                                                             : CW'(fiu_reg);
    assign base_aligned = {base_reg[ADDR_W-1:FS], {FS{1'b0}}};
    assign size_sum = {1'b0, in_size_bytes} + XW'(FRAME_BYTES - 1);
    assign free_off = {1'b0, in_free_address} - {1'b0, base_aligned};

    assign ptr_idx     = ptr_reg[IW-1:0];
    assign ptr_lt_n    = (ptr_reg < n_cnt);
    assign run_plus    = run_reg + 1'b1;
    assign rd_taken    = rdata_reg[MARK_TAKEN_BIT];
    assign found       = rv_reg && !rd_taken && (XW'(run_plus) == XW'(need_reg));
    assign start_found = (run_reg == '0) ? ridx_reg : start_reg;
    assign need_m1     = IW'(need_reg - 1'b1);

    always_comb begin
        mark_word = '0;
        mark_word[MARK_TAKEN_BIT] = 1'b1;
        mark_word[MARK_FIRST_BIT] = (ptr_idx == start_reg);
        mark_word[MARK_NEXT_BIT]  = (ptr_idx != last_reg);
    end

    assign rd_en   = (cmd.scan_step && ptr_lt_n) || cmd.free_rd;
    assign wr_en   = cmd.sweep_wr || cmd.mark_wr || cmd.free_wr;
    assign wr_data = cmd.mark_wr ? mark_word : '0;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mark_mem[ptr_idx] <= wr_data;
        end
        if (rd_en) begin
            rdata_reg <= mark_mem[ptr_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= '0;
            fiu_reg  <= FIU_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_BASE: base_reg <= cfg_wdata;
                CFG_FIU:  fiu_reg  <= cfg_wdata[FIU_W-1:0];
                default:  ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            act_reg   <= in_action;
            need_reg  <= size_sum[XW-1:FS];
            below_reg <= free_off[XW-1];
            idx_reg   <= free_off[ADDR_W-1:FS];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg <= '0;
            rv_reg  <= 1'b0;
        end else begin
            priority if (cmd.ptr_clr) begin
                ptr_reg <= '0;
                rv_reg  <= 1'b0;
            end else if (cmd.free_load) begin
                ptr_reg <= CW'(idx_reg);
            end else if (cmd.scan_step) begin
                if (found) begin
                    ptr_reg <= CW'(start_found);
                    rv_reg  <= 1'b0;
                end else begin
                    rv_reg <= ptr_lt_n;
                    if (ptr_lt_n) begin
                        ptr_reg <= ptr_reg + 1'b1;
                    end
                end
            end else if (cmd.sweep_wr || cmd.mark_wr || cmd.free_wr) begin
                ptr_reg <= (cmd.sweep_wr && st.sweep_last) ? '0 : ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.ptr_clr) begin
            run_reg <= '0;
        end else if (cmd.scan_step) begin
            ridx_reg <= ptr_idx;
            if (found) begin
                start_reg <= start_found;
                last_reg  <= start_found + need_m1;
            end else if (rv_reg) begin
                if (rd_taken) begin
                    run_reg <= '0;
                end else begin
                    if (run_reg == '0) begin
                        start_reg <= ridx_reg;
                    end
                    run_reg <= run_plus;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.resp_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.resp_load) begin
            out_addr_reg <= cmd.resp_use_addr
                          ? base_aligned + (ADDR_W'(start_reg) << FS) : '0;
            out_stat_reg <= cmd.resp_stat;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_addr_reg;
    assign m_tuser  = out_stat_reg;

    always_comb begin
        st            = '0;
        st.act        = act_reg;
        st.need_zero  = (need_reg == '0);
        st.need_over  = (XW'(need_reg) > XW'(n_cnt));
        st.free_bad   = below_reg || (XW'(idx_reg) >= XW'(n_cnt));
        st.sweep_last = (ptr_idx == IW'(TABLE_DEPTH - 1));
        st.found      = found;
        st.scan_end   = !rv_reg && !ptr_lt_n;
        st.mark_last  = (ptr_idx == last_reg);
        st.free_more  = rdata_reg[MARK_NEXT_BIT] && ((ptr_reg + 1'b1) < n_cnt);
        st.out_free   = !out_valid_reg || m_tready;
    end

endmodule

`default_nettype wire

// ----- src/contiguous_frame_allocator.sv -----
// First-fit allocator of contiguous page frames.
// s_ channel: one request beat; s_tuser = action, s_tdata = size and free address.
// m_ channel: one response beat per request; m_tdata = block address,
// m_tuser = status. cfg_* writes base_address (index 0) or frames_in_use
// (index 1); the user must write only while the block is idle (unenforced).
// Work per request, from accept to response valid, with n managed frames:
//   bad or oversized allocate, bad free, unknown action: answered from decode
//   allocate: scans up to n frames, then marks each frame of the found run
//   free: reads and then clears each frame in the released chain
//   clear: writes all TABLE_DEPTH table entries, one table write per cycle
// The frame table has a single read/write port; one request is worked at a
// time, so the scan and the write sweeps set the throughput.
// After reset s_tready stays low while the table is swept to all free. A
// response waits in an output register while m_tready is low; the next
// request is still taken and held ready to answer.
`default_nettype none

module contiguous_frame_allocator #(
    parameter int unsigned TABLE_DEPTH = cfa_pkg::DEF_TABLE_DEPTH,
    parameter int unsigned FRAME_BYTES = cfa_pkg::DEF_FRAME_BYTES
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [cfa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [cfa_pkg::ADDR_W-1:0]     cfg_wdata,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [63:0]                    s_tdata,  // size_bytes, free_address
    input  wire logic [cfa_pkg::ACT_W-1:0]      s_tuser,  // action
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [cfa_pkg::ADDR_W-1:0]          m_tdata,  // block_address
    output logic [cfa_pkg::STAT_W-1:0]          m_tuser   // status
);
    import cfa_pkg::*;

    `include "assert_macros.svh"

    cfa_cmd_t  cmd;
    cfa_stat_t st;

    cfa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    cfa_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .FRAME_BYTES (FRAME_BYTES)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .in_action       (s_tuser),
        .in_size_bytes   (s_tdata[31:0]),
        .in_free_address (s_tdata[63:32]),
        .cmd             (cmd),
        .st              (st),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser)
    );

    `CFA_ASSERT_NXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "request taken while busy")
    `CFA_ASSERT_IMP(a_stat_code, m_tvalid, m_tuser <= STAT_BAD, "bad status")
    `CFA_ASSERT_IMP(a_fail_zero, m_tvalid && m_tuser != STAT_OK, m_tdata == '0, "fail addr")

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
`default_nettype none

module tb;
    import cfa_pkg::*;

    localparam int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH;
    localparam int unsigned FRAME_BYTES = DEF_FRAME_BYTES;
    localparam logic [ACT_W-1:0] ACT_UNKNOWN = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 4_000_000;
    localparam int unsigned SETTLE_CYCLES = 4;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [ADDR_W-1:0] size_bytes;
        logic [ADDR_W-1:0] free_address;
        logic              drain_first;
    } request_t;

    typedef struct packed {
        logic [ADDR_W-1:0] block_address;
        logic [STAT_W-1:0] status;
    } response_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [ADDR_W-1:0]    cfg_wdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [63:0]          s_tdata = '0;
    logic [ACT_W-1:0]     s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [ADDR_W-1:0]    m_tdata;
    logic [STAT_W-1:0]    m_tuser;

    // shadow of the frame table and of the registers
    logic [MARK_W-1:0] shadow_marks [TABLE_DEPTH];
    logic [ADDR_W-1:0] cfg_base;
    logic [FIU_W-1:0]  cfg_fiu;

    request_t    pending_requests[$];
    response_t   expected_responses[$];
    request_t    drv_req;
    request_t    issue_req;
    response_t   exp_rsp;
    bit          drv_busy = 1'b0;

    int unsigned src_idle_pct = 0;
    int unsigned snk_idle_pct = 0;
    int unsigned cycle_count = 0;
    int unsigned mismatches = 0;
    int unsigned actions_sent [4] = '{default: 0};
    int unsigned status_seen [4] = '{default: 0};
    int unsigned settings_visited = 1;

    contiguous_frame_allocator #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .FRAME_BYTES (FRAME_BYTES)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("** contiguous_frame_allocator: FAILED **");
            $finish;
        end
    end

    function automatic int unsigned managed_frames();
        return (cfg_fiu > TABLE_DEPTH) ? TABLE_DEPTH : int'(cfg_fiu);
    endfunction

    function automatic logic [ADDR_W-1:0] frame_base();
        return cfg_base - (cfg_base % FRAME_BYTES);
    endfunction

    // First-fit allocation, chain release and table clear on the shadow table.
    function automatic response_t allocator_predict(input request_t req);
        response_t         rsp;
        logic [63:0]       frames_needed;
        logic [ADDR_W-1:0] base, idx;
        logic [MARK_W-1:0] m;
        int unsigned       n, run_len, run_start, last, i;
        bit                found, chain_done;
        rsp.block_address = '0;
        rsp.status = STAT_BAD;
        n = managed_frames();
        base = frame_base();
        case (req.action)
            ACT_ALLOC: begin
                frames_needed = (64'(req.size_bytes) + FRAME_BYTES - 1) / FRAME_BYTES;
                if (frames_needed == 0) begin
                    rsp.status = STAT_BAD;
                end else if (frames_needed > n) begin
                    rsp.status = STAT_NOSPACE;
                end else begin
                    run_len = 0;
                    run_start = 0;
                    found = 1'b0;
                    for (i = 0; i < n && !found; i++) begin
                        if (shadow_marks[i][MARK_TAKEN_BIT]) begin
                            run_len = 0;
                        end else begin
                            if (run_len == 0) run_start = i;
                            run_len++;
                            if (run_len == frames_needed) found = 1'b1;
                        end
                    end
                    if (!found) begin
                        rsp.status = STAT_NOSPACE;
                    end else begin
                        last = run_start + 32'(frames_needed) - 1;
                        for (i = run_start; i <= last; i++) begin
                            m = '0;
                            m[MARK_TAKEN_BIT] = 1'b1;
                            m[MARK_FIRST_BIT] = (i == run_start);
                            m[MARK_NEXT_BIT] = (i != last);
                            shadow_marks[i] = m;
                        end
                        rsp.status = STAT_OK;
                        rsp.block_address = base + run_start * FRAME_BYTES;
                    end
                end
            end
            ACT_FREE: begin
                if (req.free_address >= base) begin
                    idx = (req.free_address - base) / FRAME_BYTES;
                    if (idx < n) begin
                        chain_done = 1'b0;
                        for (i = idx; i < n && !chain_done; i++) begin
                            m = shadow_marks[i];
                            shadow_marks[i] = '0;
                            chain_done = !m[MARK_NEXT_BIT];
                        end
                        rsp.status = STAT_OK;
                    end
                end
            end
            ACT_CLEAR: begin
                for (i = 0; i < TABLE_DEPTH; i++) shadow_marks[i] = '0;
                rsp.status = STAT_OK;
            end
            default: begin
            end
        endcase
        return rsp;
    endfunction

    // Mostly allocations and releases of live runs, with odd sizes,
    // stray addresses, clears and junk mixed in.
    function automatic request_t random_request(input logic hold_for_drain);
        request_t    req;
        int unsigned n, nmax, pick, idx, i;
        int unsigned heads[$];
        n = managed_frames();
        nmax = (n == 0) ? 1 : n;
        req.action = ACT_ALLOC;
        req.size_bytes = $urandom;
        req.free_address = $urandom;
        req.drain_first = hold_for_drain;
        pick = $urandom_range(99, 0);
        if (pick < 50) begin
            pick = $urandom_range(99, 0);
            if (pick < 5)
                req.size_bytes = '0;
            else if (pick < 13)
                req.size_bytes = 32'hFFFF_FFFF - $urandom_range(8191, 0);
            else if (pick < 35)
                req.size_bytes = $urandom_range(nmax + 1, 1) * FRAME_BYTES;
            else if (pick < 90)
                req.size_bytes = $urandom_range(3 * FRAME_BYTES, 1);
        end else if (pick < 90) begin
            req.action = ACT_FREE;
            for (i = 0; i < n; i++)
                if (shadow_marks[i][MARK_TAKEN_BIT] && shadow_marks[i][MARK_FIRST_BIT])
                    heads.push_back(i);
            pick = $urandom_range(99, 0);
            if (pick < 70 && heads.size() != 0)
                idx = heads[$urandom_range(heads.size() - 1, 0)];
            else
                idx = $urandom_range(nmax + 1, 0);
            if (pick < 90)
                req.free_address = frame_base() + idx * FRAME_BYTES
                    + ($urandom_range(1, 0) ? $urandom_range(FRAME_BYTES - 1, 0) : 0);
        end else if (pick < 94) begin
            req.action = ACT_CLEAR;
        end else if (pick < 97) begin
            req.action = ACT_UNKNOWN;
        end else begin
            req.action = ACT_W'($urandom_range(3, 0));
        end
        return req;
    endfunction

    task automatic push_req(input logic [ACT_W-1:0] action, input logic [ADDR_W-1:0] size,
                            input logic [ADDR_W-1:0] addr);
        request_t req;
        req.action = action;
        req.size_bytes = size;
        req.free_address = addr;
        req.drain_first = 1'b0;
        pending_requests.push_back(req);
    endtask

    task automatic settle();
        while (pending_requests.size() != 0 || drv_busy || expected_responses.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_config(input logic [ADDR_W-1:0] base, input logic [FIU_W-1:0] fiu);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_BASE;
        cfg_wdata <= base;
        cfg_base = base;
        @(posedge aclk);
        cfg_index <= CFG_FIU;
        cfg_wdata <= ADDR_W'(fiu);
        cfg_fiu = fiu;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        settings_visited++;
    endtask

    task automatic run_random(input logic [ADDR_W-1:0] base, input logic [FIU_W-1:0] fiu,
                              input int unsigned count);
        int unsigned k;
        set_config(base, fiu);
        for (k = 0; k < count; k++) begin
            while (pending_requests.size() >= 2) @(posedge aclk);
            pending_requests.push_back(
                random_request((k == count / 2) || ($urandom_range(99, 0) < 2)));
        end
        settle();
    endtask

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_responses.push_back(allocator_predict(drv_req));
                actions_sent[drv_req.action]++;
                drv_busy = 1'b0;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_requests.size() != 0
                    && !(pending_requests[0].drain_first && expected_responses.size() != 0)
                    && $urandom_range(99, 0) >= src_idle_pct) begin
                    issue_req = pending_requests.pop_front();
                    drv_busy = 1'b1;
                    drv_req <= issue_req;
                    s_tvalid <= 1'b1;
                    s_tdata <= {issue_req.free_address, issue_req.size_bytes};
                    s_tuser <= issue_req.action;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // response monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_responses.size() == 0) begin
                    $error("response beat with none expected: block_address %h status %0d",
                           m_tdata, m_tuser);
                    mismatches++;
                end else begin
                    exp_rsp = expected_responses.pop_front();
                    if (m_tdata !== exp_rsp.block_address) begin
                        $error("block_address: expected %h, actual %h",
                               exp_rsp.block_address, m_tdata);
                        mismatches++;
                    end
                    if (m_tuser !== exp_rsp.status) begin
                        $error("status: expected %0d, actual %0d", exp_rsp.status, m_tuser);
                        mismatches++;
                    end
                    status_seen[exp_rsp.status]++;
                end
            end
            m_tready <= ($urandom_range(99, 0) >= snk_idle_pct);
        end
    end

    initial begin
        for (int unsigned i = 0; i < TABLE_DEPTH; i++) shadow_marks[i] = '0;
        cfg_base = '0;
        cfg_fiu = FIU_RESET;
        src_idle_pct = 24;
        snk_idle_pct = 79;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: base 0, full table
        push_req(ACT_ALLOC, 32'd0, $urandom);
        push_req(ACT_ALLOC, 32'd1, $urandom);
        push_req(ACT_ALLOC, FRAME_BYTES, $urandom);
        push_req(ACT_ALLOC, FRAME_BYTES + 1, $urandom);
        push_req(ACT_ALLOC, 32'hFFFF_FFFF, $urandom);
        push_req(ACT_ALLOC, TABLE_DEPTH * FRAME_BYTES, $urandom);
        push_req(ACT_FREE, $urandom, 2 * FRAME_BYTES + 5);
        push_req(ACT_FREE, $urandom, 32'd0);
        push_req(ACT_FREE, $urandom, 32'd0);
        push_req(ACT_ALLOC, 3 * FRAME_BYTES, 32'hFFFF_FFFF);
        push_req(ACT_FREE, 32'hFFFF_FFFF, 3 * FRAME_BYTES);
        push_req(ACT_FREE, $urandom, TABLE_DEPTH * FRAME_BYTES);
        push_req(ACT_FREE, $urandom, 32'hFFFF_FFFF);
        push_req(ACT_UNKNOWN, $urandom, $urandom);
        push_req(ACT_CLEAR, $urandom, $urandom);
        push_req(ACT_ALLOC, TABLE_DEPTH * FRAME_BYTES, $urandom);
        push_req(ACT_ALLOC, 32'd1, $urandom);
        push_req(ACT_FREE, $urandom, 32'd0);
        settle();

        // top base with wrap, oversized frame count
        set_config(32'hFFFF_FFFF, 11'd2047);
        push_req(ACT_ALLOC, 8 * FRAME_BYTES, $urandom);
        push_req(ACT_ALLOC, 32'd1, $urandom);
        settle();
        // chain now runs past the managed range
        set_config(32'hFFFF_FFFF, 11'd4);
        push_req(ACT_FREE, $urandom, 32'hFFFF_F123);
        push_req(ACT_ALLOC, 4 * FRAME_BYTES, $urandom);
        push_req(ACT_FREE, $urandom, 32'd5);
        settle();
        set_config(32'd0, 11'd0);
        push_req(ACT_ALLOC, 32'd1, $urandom);
        push_req(ACT_FREE, $urandom, 32'd0);
        push_req(ACT_CLEAR, $urandom, $urandom);
        settle();

        run_random($urandom, 11'd16, 100);
        run_random(32'd0, 11'd1024, 80);
        src_idle_pct = 79;
        snk_idle_pct = 24;
        run_random($urandom, 11'd2047, 80);
        run_random(32'h0000_1FFF, 11'd40, 100);
        run_random($urandom, 11'd0, 10);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        run_random(32'hFFFF_FFFF, 11'd1, 60);
        run_random($urandom, 11'd200, 150);

        repeat (2 * TABLE_DEPTH + 8) @(posedge aclk);
        $display("covered %0d allocate, %0d free, %0d clear, %0d unknown-action requests",
                 actions_sent[ACT_ALLOC], actions_sent[ACT_FREE], actions_sent[ACT_CLEAR],
                 actions_sent[ACT_UNKNOWN]);
        $display("over %0d register settings: %0d ok, %0d out of space, %0d rejected",
                 settings_visited, status_seen[STAT_OK], status_seen[STAT_NOSPACE],
                 status_seen[STAT_BAD]);
        if (mismatches == 0 && expected_responses.size() == 0) begin
            $display("** contiguous_frame_allocator: PASSED **");
        end else begin
            $display("** contiguous_frame_allocator: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire
